// ===== rtl/chtt_pkg.sv =====
package chtt_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [31:0] HASH_MUL_B = 32'd17;
  localparam logic [31:0] HASH_MUL_C = 32'd751;
  localparam logic [3:0] RESET_ROUNDS = 4'd5;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_TAKE   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DROPPED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_CHECK,
    BS_DONE
  } back_state_t;

  // One classified word travelling from the front end to the back end.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic        owned;
  } job_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_value;
    logic        found_owned;
    logic [31:0] dropped_key;
    logic [31:0] dropped_value;
  } result_t;

  // Candidate slot for hash 0, 1 or 2 of a key.
  function automatic logic [IDX_W-1:0] slot_of(input logic [31:0] key,
                                               input logic [1:0] which);
    logic [31:0] h;
    begin
      case (which)
        2'd1:    h = key * HASH_MUL_B;
        2'd2:    h = key * HASH_MUL_C;
        default: h = key;
      endcase
      slot_of = h[IDX_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/chtt_front.sv =====
module chtt_front
  import chtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic        in_value_owned,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;
  logic             push, pop;

  assign in_ready  = (cnt_r != QUEUE_DEPTH[PTR_W:0]);
  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{cmd: cmd_t'(in_command), key: in_key, value: in_value,
                     owned: in_value_owned};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end
  end

endmodule

// ===== rtl/chtt_back.sv =====
module chtt_back
  import chtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  max_rounds,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  // Each slot word holds valid bit, key, value and owned flag in one memory.
  logic [65:0]            mem [TABLE_SLOTS];
  logic [65:0]            rd_r;

  back_state_t state_r, state_nxt;
  job_t        cur_r, cur_nxt;
  logic [1:0]  way_r, way_nxt;
  logic [5:0]  kicks_r, kicks_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  result_t     res_r, res_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic        wr_en;
  logic [65:0] wr_data;
  logic [5:0]  kick_limit;

  assign kick_limit = {2'b00, max_rounds} + {1'b0, max_rounds, 1'b0};
  assign job_ready  = (state_r == BS_IDLE) && !res_valid_r;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    way_nxt       = way_r;
    kicks_nxt     = kicks_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    wr_en         = 1'b0;
    wr_data       = {1'b1, cur_r.key, cur_r.value, cur_r.owned};
    if (res_valid_r && res_ready) res_valid_nxt = 1'b0;
    case (state_r)
      BS_CLEAR: begin
        // Empty one slot per cycle after reset.
        wr_en   = 1'b1;
        wr_data = '0;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(TABLE_SLOTS - 1)) state_nxt = BS_IDLE;
      end
      BS_IDLE: begin
        if (job_valid && job_ready) begin
          cur_nxt   = job;
          way_nxt   = 2'd0;
          kicks_nxt = '0;
          res_nxt   = '{status: ST_NOT_FOUND, default: '0};
          if (job.cmd == CMD_PUT && kicks_nxt == kick_limit) begin
            res_nxt = '{status: ST_DROPPED, found_value: '0, found_owned: 1'b0,
                        dropped_key: job.key, dropped_value: job.value};
            state_nxt = BS_DONE;
          end else if (job.cmd == CMD_NONE) begin
            state_nxt = BS_DONE;
          end else begin
            idx_nxt   = slot_of(job.key, 2'd0);
            state_nxt = BS_READ;
          end
        end
      end
      BS_READ: state_nxt = BS_CHECK;
      BS_CHECK: begin
        if (cur_r.cmd == CMD_PUT) begin
          wr_en = 1'b1;
          if (!rd_r[65]) begin
            res_nxt.status = ST_INSERTED;
            state_nxt      = BS_DONE;
          end else if (rd_r[64:33] == cur_r.key) begin
            res_nxt.status = ST_REPLACED;
            state_nxt      = BS_DONE;
          end else begin
            cur_nxt.key   = rd_r[64:33];
            cur_nxt.value = rd_r[32:1];
            cur_nxt.owned = rd_r[0];
            kicks_nxt     = kicks_r + 6'd1;
            way_nxt       = (way_r == 2'd2) ? 2'd0 : way_r + 2'd1;
            if (kicks_nxt == kick_limit) begin
              res_nxt = '{status: ST_DROPPED, found_value: '0, found_owned: 1'b0,
                          dropped_key: rd_r[64:33], dropped_value: rd_r[32:1]};
              state_nxt = BS_DONE;
            end else begin
              idx_nxt   = slot_of(rd_r[64:33], way_nxt);
              state_nxt = BS_READ;
            end
          end
        end else begin
          if (rd_r[65] && rd_r[64:33] == cur_r.key) begin
            res_nxt.status      = ST_FOUND;
            res_nxt.found_value = rd_r[32:1];
            res_nxt.found_owned = rd_r[0];
            wr_en               = (cur_r.cmd == CMD_TAKE) && rd_r[0];
            wr_data             = {1'b0, rd_r[64:0]};
            state_nxt           = BS_DONE;
          end else if (way_r == 2'd2) begin
            state_nxt = BS_DONE;
          end else begin
            way_nxt   = way_r + 2'd1;
            idx_nxt   = slot_of(cur_r.key, way_nxt);
            state_nxt = BS_READ;
          end
        end
      end
      BS_DONE: begin
        res_valid_nxt = 1'b1;
        state_nxt     = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[idx_r];
    if (wr_en) mem[idx_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    way_r       <= way_nxt;
    kicks_r     <= kicks_nxt;
    res_r       <= res_nxt;
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      res_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ===== rtl/cuckoo_hash_table_three_way.sv =====
// Channel | Direction | Ports
// input   | in        | in_valid, in_ready, in_command, in_key, in_value, in_value_owned
// result  | out       | out_valid, out_ready, out_status, out_found_value, out_found_owned,
//         |           | out_dropped_key, out_dropped_value
// config  | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
// A lookup or take probes up to three slots, each with a memory read state and then
// a compare state; a put probes one slot per kick, up to 3*max_rounds kicks, and all
// probes share the single port of the slot memory.
// Synchronous active-low reset sets max_rounds to 5 and starts a clearing pass that
// empties one slot per cycle, all 1024 of them, before the back end takes a word.
// A two-word queue lets the input side accept words while the back end works,
// and a held result stalls the back end, and the input side once the queue is full.
module cuckoo_hash_table_three_way
  import chtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic        in_value_owned,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_value,
  output logic        out_found_owned,
  output logic [31:0] out_dropped_key,
  output logic [31:0] out_dropped_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       job_valid, job_ready;
  job_t       job;
  result_t    res;
  logic [3:0] max_rounds_r;

  // The only register sits at byte address zero.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, max_rounds_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rounds_r <= RESET_ROUNDS;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      max_rounds_r <= pwdata[3:0];
    end
  end

  chtt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_key, .in_value,
    .in_value_owned, .job_valid, .job_ready, .job
  );

  chtt_back u_back (
    .clk, .rst_n, .max_rounds(max_rounds_r), .job_valid, .job_ready, .job,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_status        = res.status;
  assign out_found_value   = res.found_value;
  assign out_found_owned   = res.found_owned;
  assign out_dropped_key   = res.dropped_key;
  assign out_dropped_value = res.dropped_value;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import chtt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = 2'd0;
  logic [31:0] in_key = 32'd0;
  logic [31:0] in_value = 32'd0;
  logic        in_value_owned = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_found_value;
  logic        out_found_owned;
  logic [31:0] out_dropped_key;
  logic [31:0] out_dropped_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  localparam logic [1:0] ADDR_MAX_ROUNDS = 2'd0;

  cuckoo_hash_table_three_way DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_key(in_key), .in_value(in_value), .in_value_owned(in_value_owned),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_found_value(out_found_value), .out_found_owned(out_found_owned),
    .out_dropped_key(out_dropped_key), .out_dropped_value(out_dropped_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // One request word and one answer word.
  typedef struct {
    cmd_t        cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic        owned;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] found_value;
    logic        found_owned;
    logic [31:0] dropped_key;
    logic [31:0] dropped_value;
  } answer_t;

  // Shadow of the slot store and the round count. The shadow is updated when a
  // request word is accepted; since the block serves words in order, the
  // answers predicted here line up with the answers it returns.
  logic        shadow_valid [TABLE_SLOTS];
  logic [31:0] shadow_key [TABLE_SLOTS];
  logic [31:0] shadow_value [TABLE_SLOTS];
  logic        shadow_owned [TABLE_SLOTS];
  logic [3:0]  shadow_rounds;

  request_t pending_requests[$];
  answer_t  expected_answers[$];

  int mismatches = 0;
  int answers_seen = 0;
  int drops_seen = 0;
  int requests_sent = 0;
  bit hold_off = 1'b0;
  bit in_accepted = 1'b0;

  function automatic logic [IDX_W-1:0] candidate(logic [31:0] key, int unsigned which);
    logic [31:0] h;
    h = (which == 1) ? key * 32'd17 : (which == 2) ? key * 32'd751 : key;
    return h[IDX_W-1:0];
  endfunction

  // Applies one request to the shadow table and returns the answer it gives.
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    logic [31:0] k, v, ok, ov;
    logic o, oo, wasv, done;
    logic [IDX_W-1:0] i;
    int unsigned kicks;
    a.status = ST_NOT_FOUND;
    a.found_value = '0;
    a.found_owned = 1'b0;
    a.dropped_key = '0;
    a.dropped_value = '0;
    k = r.key;
    v = r.value;
    o = r.owned;
    done = 1'b0;
    kicks = shadow_rounds * 3;
    if (r.cmd == CMD_PUT) begin
      for (int unsigned n = 0; n < kicks && !done; n++) begin
        i = candidate(k, n % 3);
        wasv = shadow_valid[i];
        ok = shadow_key[i];
        ov = shadow_value[i];
        oo = shadow_owned[i];
        shadow_valid[i] = 1'b1;
        shadow_key[i] = k;
        shadow_value[i] = v;
        shadow_owned[i] = o;
        if (!wasv) begin
          a.status = ST_INSERTED;
          done = 1'b1;
        end else if (ok == k) begin
          a.status = ST_REPLACED;
          done = 1'b1;
        end else begin
          k = ok;
          v = ov;
          o = oo;
        end
      end
      if (!done) begin
        a.status = ST_DROPPED;
        a.dropped_key = k;
        a.dropped_value = v;
      end
    end else if (r.cmd == CMD_LOOKUP || r.cmd == CMD_TAKE) begin
      for (int unsigned w = 0; w < 3; w++) begin
        i = candidate(k, w);
        if (!done && shadow_valid[i] && shadow_key[i] == k) begin
          a.status = ST_FOUND;
          a.found_value = shadow_value[i];
          a.found_owned = shadow_owned[i];
          if (r.cmd == CMD_TAKE && shadow_owned[i]) shadow_valid[i] = 1'b0;
          done = 1'b1;
        end
      end
    end
    return a;
  endfunction

  // Remembers whether the word on the input was taken at the last rising edge.
  always @(posedge clk) begin
    in_accepted <= rst_n && in_valid && in_ready;
  end

  // Driver: bursts of words separated by random gaps. Valid stays up while a
  // word waits, and the next word replaces it only once it is accepted.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_accepted) begin
        // The current word has not been taken yet; hold it.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request_t r;
        r = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_command <= r.cmd;
        in_key <= r.key;
        in_value <= r.value;
        in_value_owned <= r.owned;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: runs of ready and of stall of random length,
  // overridden by the long hold-off.
  int ready_run = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
      ready_run <= $urandom_range(0, 15);
    end
  end

  // Monitor: predicts on accepted request words and checks accepted answers.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      request_t r;
      r.cmd = cmd_t'(in_command);
      r.key = in_key;
      r.value = in_value;
      r.owned = in_value_owned;
      expected_answers.push_back(apply_request(r));
      requests_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      answer_t e;
      answers_seen++;
      if (out_status == ST_DROPPED) drops_seen++;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer word, status %0d", out_status);
      end else begin
        e = expected_answers.pop_front();
        if (out_status !== e.status || out_found_value !== e.found_value ||
            out_found_owned !== e.found_owned || out_dropped_key !== e.dropped_key ||
            out_dropped_value !== e.dropped_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d fv=%h fo=%b dk=%h dv=%h",
                      " / got st=%0d fv=%h fo=%b dk=%h dv=%h"},
                     e.status, e.found_value, e.found_owned, e.dropped_key,
                     e.dropped_value, out_status, out_found_value, out_found_owned,
                     out_dropped_key, out_dropped_value);
        end
      end
    end
  end

  // Waits until every queued word has gone in and every answer is back, then
  // lets the block settle before the next register write.
  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle. Inputs change on the falling edge.
  task automatic write_rounds(logic [3:0] rounds);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_ROUNDS;
    pwdata <= {28'd0, rounds};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_rounds = rounds;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic request_t make_request(cmd_t c, logic [31:0] k, logic [31:0] v, logic o);
    request_t r;
    r.cmd = c;
    r.key = k;
    r.value = v;
    r.owned = o;
    return r;
  endfunction

  // Keys drawn from a small pool so that puts collide, kick and replace,
  // and lookups and takes usually hit. Some keys use the full 32-bit range.
  function automatic logic [31:0] pick_key(int unsigned pool);
    logic [31:0] k;
    if ($urandom_range(0, 9) == 0) return $urandom;
    k = $urandom_range(0, pool - 1);
    // Multiples of the table size share their first slot, which forces kicks.
    if ($urandom_range(0, 2) == 0) k = k * TABLE_SLOTS + ($urandom_range(0, 3) << 20);
    return k;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned pool);
    cmd_t c;
    int unsigned roll;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) c = CMD_PUT;
      else if (roll < 72) c = CMD_LOOKUP;
      else if (roll < 97) c = CMD_TAKE;
      else c = CMD_NONE;
      pending_requests.push_back(make_request(c, pick_key(pool), $urandom,
                                              1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
      shadow_owned[i] = 1'b0;
    end
    shadow_rounds = RESET_ROUNDS;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset round count: an empty lookup, all-ones fields,
    // a replace, an owned and a borrowed take, and the unused command.
    pending_requests.push_back(make_request(CMD_LOOKUP, 32'd0, 32'd0, 1'b0));
    pending_requests.push_back(make_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    pending_requests.push_back(make_request(CMD_PUT, 32'd0, 32'd0, 1'b0));
    pending_requests.push_back(make_request(CMD_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0));
    pending_requests.push_back(make_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0));
    pending_requests.push_back(make_request(CMD_TAKE, 32'hFFFF_FFFF, 32'd0, 1'b1));
    pending_requests.push_back(make_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0));
    pending_requests.push_back(make_request(CMD_PUT, 32'd5, 32'hA5A5_A5A5, 1'b1));
    pending_requests.push_back(make_request(CMD_TAKE, 32'd5, 32'd0, 1'b0));
    pending_requests.push_back(make_request(CMD_TAKE, 32'd5, 32'd0, 1'b0));
    pending_requests.push_back(make_request(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    // Keys that all share their first slot: the later puts kick the earlier
    // entries on, a kick chain can meet a key it carries and end as replaced,
    // and a long enough chain drops an entry.
    for (int i = 1; i <= 8; i++)
      pending_requests.push_back(make_request(CMD_PUT, i * TABLE_SLOTS * 3, 32'(i), 1'b1));
    pending_requests.push_back(make_request(CMD_PUT, 32'd3072, 32'hDEAD_BEEF, 1'b0));
    pending_requests.push_back(make_request(CMD_TAKE, 32'd3072, 32'd0, 1'b0));
    drain();

    // Zero rounds: every put drops its own entry and stores nothing.
    write_rounds(4'd0);
    pending_requests.push_back(make_request(CMD_PUT, 32'd77, 32'h0BAD_F00D, 1'b1));
    pending_requests.push_back(make_request(CMD_LOOKUP, 32'd77, 32'd0, 1'b0));
    random_phase(40, 64);
    drain();

    // One round fills up fast with a small key pool, so drops are common.
    write_rounds(4'd1);
    random_phase(400, 48);

    // Long receiver hold-off while the sender keeps offering words, so the
    // internal queue fills and the input side stalls.
    wait (pending_requests.size() < 300);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b0;
    drain();

    write_rounds(4'd15);
    random_phase(400, 1500);
    drain();

    write_rounds(4'd3);
    random_phase(400, 700);
    drain();

    write_rounds(4'd5);
    random_phase(400, 300);
    drain();

    $display("Sent %0d request words over round counts 5, 0, 1, 15, 3, 5.", requests_sent);
    $display("Checked %0d answer words, %0d of them dropped entries.", answers_seen, drops_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatching answer words", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of every phase.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/chtt_pkg.sv
rtl/chtt_front.sv
rtl/chtt_back.sv
rtl/cuckoo_hash_table_three_way.sv
tb/sv/tb.sv
